[src/lobm_pkg.sv]
// Package: shared types and codes of the limit order book matcher.
`default_nettype none
package lobm_pkg;

    localparam logic [16:0] NO_PRICE = 17'h10000;

    localparam logic       OP_ADD    = 1'b0;
    localparam logic       OP_CANCEL = 1'b1;
    localparam logic       SIDE_BUY  = 1'b0;
    localparam logic       SIDE_SELL = 1'b1;
    localparam logic       TYPE_LIMIT  = 1'b0;
    localparam logic       TYPE_MARKET = 1'b1;
    localparam logic [1:0] TIF_GTC = 2'd0;
    localparam logic [1:0] TIF_DAY = 2'd1;
    localparam logic [1:0] TIF_IOC = 2'd2;
    localparam logic [1:0] TIF_FOK = 2'd3;

    localparam logic [2:0] KIND_TRADE     = 3'd0;
    localparam logic [2:0] KIND_RESTED    = 3'd1;
    localparam logic [2:0] KIND_DONE      = 3'd2;
    localparam logic [2:0] KIND_FOK_REJ   = 3'd3;
    localparam logic [2:0] KIND_CANCELLED = 3'd4;
    localparam logic [2:0] KIND_CXL_UNK   = 3'd5;
    localparam logic [2:0] KIND_FULL      = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOK_SCAN,
        ST_MATCH_SCAN,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_REST,
        ST_CAN_SCAN,
        ST_BEST_SCAN,
        ST_PLAY_RD,
        ST_PLAY_LD,
        ST_PLAY_WT,
        ST_STAT,
        ST_STAT_WT
    } t_state;

    typedef struct packed {
        logic        side;
        logic [15:0] price;
        logic [31:0] order_id;
        logic [15:0] client_id;
        logic [31:0] remaining;
        logic [31:0] arrival;
    } t_slot;

    typedef struct packed {
        logic [31:0] trade_id;
        logic [15:0] price;
        logic [31:0] quantity;
        logic [31:0] order_id;
        logic [15:0] client_id;
    } t_trade;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] trade_id;
        logic [15:0] fill_price;
        logic [31:0] fill_quantity;
        logic [31:0] buyer_oid;
        logic [31:0] seller_oid;
        logic [15:0] buyer_cid;
        logic [15:0] seller_cid;
        logic        taker_side;
        logic [16:0] best_bid;
        logic [16:0] best_ask;
        logic        last;
    } t_res;

endpackage
`default_nettype wire

[src/lobm_if.sv]
// Interfaces: request channel and result channel with valid/ready handshake.
`default_nettype none
interface lobm_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] order_id;
    logic [15:0] client_id;
    logic        side;
    logic        order_type;
    logic [1:0]  time_in_force;
    logic [15:0] price;
    logic [31:0] quantity;

    modport source (output valid, opcode, order_id, client_id, side, order_type,
                     time_in_force, price, quantity, input ready);
    modport sink   (input valid, opcode, order_id, client_id, side, order_type,
                    time_in_force, price, quantity, output ready);
endinterface

interface lobm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] trade_id;
    logic [15:0] fill_price;
    logic [31:0] fill_quantity;
    logic [31:0] buyer_oid;
    logic [31:0] seller_oid;
    logic [15:0] buyer_cid;
    logic [15:0] seller_cid;
    logic        taker_side;
    logic [16:0] best_bid;
    logic [16:0] best_ask;
    logic        last;

    modport source (output valid, kind, trade_id, fill_price, fill_quantity,
                     buyer_oid, seller_oid, buyer_cid, seller_cid,
                     taker_side, best_bid, best_ask, last, input ready);
    modport sink   (input valid, kind, trade_id, fill_price, fill_quantity,
                    buyer_oid, seller_oid, buyer_cid, seller_cid,
                    taker_side, best_bid, best_ask, last, output ready);
endinterface
`default_nettype wire

[src/lobm_free_find.sv]
// Free slot finder: lowest index whose valid bit is clear.
`default_nettype none
module lobm_free_find #(
    parameter int N  = 32,
    parameter int AW = 5
) (
    input  wire logic [N-1:0]  i_valid,
    output logic               o_found,
    output logic [AW-1:0]      o_idx
);
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (!i_valid[k]) begin
                o_found = 1'b1;
                o_idx   = AW'(k);
            end
        end
    end
endmodule
`default_nettype wire

[src/limit_order_book_matcher.sv]
// Top level: price-time priority limit order book with a slot memory.
//
// Channels: i_in takes one request item (add or cancel) when valid and
// ready are high; o_out returns the result items of that request: one
// trade item per fill, then one status item with last set. All items of a
// request carry the best bid and ask as they stand at the end of it.
// The block works on one request at a time; i_in.ready is high only while
// it waits for a new request.
// Each pass reads the slot memory through its single read port. A cancel
// takes two passes; an add one match pass (a fill-or-kill add first
// makes a check pass, and goes straight to the best-price pass if it is
// rejected), then per fill the fill read and write states and a new match
// pass, cut short once the order is filled, then one more pass for the
// best prices. Each trade item leaves via the play read, load and wait
// states, the status item via the status and status wait states.
// Reset empties the book (slot valid bits cleared), sets the arrival count
// to zero and the trade number to one. A stalled receiver holds the result
// register and the sequencer waits on it; nothing is dropped.
`default_nettype none
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int MAX_ORDERS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lobm_in_if.sink     i_in,
    lobm_out_if.source  o_out
);
    localparam int AW   = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int IW   = $clog2(MAX_ORDERS + 1);
    localparam int SUMW = 32 + IW;
    localparam logic [IW-1:0] IDX_END = IW'(MAX_ORDERS);

    t_state r_state, n_state;

    // slot memory, valid bits, trade buffer
    t_slot  r_mem [MAX_ORDERS];
    t_slot  r_rdata;
    t_trade r_tbuf [MAX_ORDERS];
    t_trade r_tdata;
    logic [MAX_ORDERS-1:0] r_valid;

    // captured request
    logic        r_side, r_mkt;
    logic [31:0] r_oid, r_rem;
    logic [15:0] r_cid, r_price;
    logic [1:0]  r_tif;

    // scan control
    logic [IW-1:0] r_idx;
    logic          r_dv;
    logic [AW-1:0] r_didx;

    logic          r_bfound;
    logic [AW-1:0] r_bidx;
    logic [15:0]   r_bprice;
    logic [31:0]   r_bage;
    logic [SUMW-1:0] r_sum;
    logic          r_cfound;
    logic [AW-1:0] r_cidx;
    logic [31:0]   r_cqty;
    logic [16:0]   r_bb, r_ba;

    logic [2:0]    r_kind;
    logic [31:0]   r_rest_qty;
    logic [31:0]   r_arr, r_trn;
    logic [IW-1:0] r_ntr, r_pidx;

    logic  r_ov;
    t_res  r_o;

    logic          is_scan, n_is_scan, issue, scan_done;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_slot         wr_data;
    logic          rside, elig, better;
    logic [31:0]   age, fill;
    logic          free_found;
    logic [AW-1:0] free_idx;
    logic          do_rest;
    logic          accept, taken;

    assign accept = i_in.valid && i_in.ready;
    assign taken  = r_ov && o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    assign is_scan   = (r_state == ST_FOK_SCAN) || (r_state == ST_MATCH_SCAN) ||
                       (r_state == ST_CAN_SCAN) || (r_state == ST_BEST_SCAN);
    assign n_is_scan = (n_state == ST_FOK_SCAN) || (n_state == ST_MATCH_SCAN) ||
                       (n_state == ST_CAN_SCAN) || (n_state == ST_BEST_SCAN);
    assign issue     = is_scan && (r_idx != IDX_END);
    assign scan_done = (r_idx == IDX_END) && !r_dv;

    // eligibility and priority of the slot just read
    assign rside  = ~r_side;
    assign elig   = r_valid[r_didx] && (r_rdata.side == rside) &&
                    (r_mkt || ((rside == SIDE_SELL) ? (r_price >= r_rdata.price)
                                                    : (r_price <= r_rdata.price)));
    assign age    = r_arr - r_rdata.arrival;
    assign better = (r_rdata.price != r_bprice)
                    ? ((rside == SIDE_SELL) ? (r_rdata.price < r_bprice)
                                            : (r_rdata.price > r_bprice))
                    : (age > r_bage);
    assign fill   = (r_rem < r_rdata.remaining) ? r_rem : r_rdata.remaining;
    assign do_rest = !((r_rem == 32'd0) || r_mkt || (r_tif == TIF_IOC) ||
                       (r_tif == TIF_FOK)) && free_found;

    lobm_free_find #(.N(MAX_ORDERS), .AW(AW)) u_free (
        .i_valid (r_valid),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    // memory port selection
    always_comb begin
        rd_addr = (r_state == ST_FILL_RD) ? r_bidx : r_idx[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_bidx;
        wr_data = r_rdata;
        if (r_state == ST_FILL_WR) begin
            wr_en             = 1'b1;
            wr_data.remaining = r_rdata.remaining - fill;
        end else if (r_state == ST_REST && do_rest) begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
            wr_data = '{side: r_side, price: r_price, order_id: r_oid,
                        client_id: r_cid, remaining: r_rem, arrival: r_arr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
        if (r_state == ST_FILL_WR) begin
            r_tbuf[r_ntr[AW-1:0]] <= '{trade_id: r_trn, price: r_rdata.price,
                                       quantity: fill, order_id: r_rdata.order_id,
                                       client_id: r_rdata.client_id};
        end
        r_tdata <= r_tbuf[r_pidx[AW-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.opcode == OP_CANCEL)          n_state = ST_CAN_SCAN;
                    else if (i_in.time_in_force == TIF_FOK) n_state = ST_FOK_SCAN;
                    else                                    n_state = ST_MATCH_SCAN;
                end
            end
            ST_FOK_SCAN: begin
                if (scan_done) begin
                    n_state = (r_sum < SUMW'(r_rem)) ? ST_BEST_SCAN : ST_MATCH_SCAN;
                end
            end
            ST_MATCH_SCAN: begin
                if (r_rem == 32'd0)  n_state = ST_REST;
                else if (scan_done)  n_state = r_bfound ? ST_FILL_RD : ST_REST;
            end
            ST_FILL_RD:   n_state = ST_FILL_WR;
            ST_FILL_WR:   n_state = ST_MATCH_SCAN;
            ST_REST:      n_state = ST_BEST_SCAN;
            ST_CAN_SCAN:  if (scan_done) n_state = ST_BEST_SCAN;
            ST_BEST_SCAN: begin
                if (scan_done) n_state = (r_ntr != '0) ? ST_PLAY_RD : ST_STAT;
            end
            ST_PLAY_RD:   n_state = ST_PLAY_LD;
            ST_PLAY_LD:   n_state = ST_PLAY_WT;
            ST_PLAY_WT: begin
                if (taken) n_state = (r_pidx + 1'b1 == r_ntr) ? ST_STAT : ST_PLAY_RD;
            end
            ST_STAT:      n_state = ST_STAT_WT;
            ST_STAT_WT:   if (taken) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_arr   <= 32'd0;
            r_trn   <= 32'd1;
            r_ov    <= 1'b0;
            r_dv    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_dv   <= issue;
            r_didx <= r_idx[AW-1:0];
            if (n_is_scan && (n_state != r_state)) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == ST_FILL_WR) begin
                r_trn <= r_trn + 32'd1;
                if (r_rdata.remaining == fill) r_valid[r_bidx] <= 1'b0;
            end
            if (r_state == ST_REST && do_rest) begin
                r_valid[free_idx] <= 1'b1;
                r_arr             <= r_arr + 32'd1;
            end
            if (r_state == ST_CAN_SCAN && scan_done && r_cfound) begin
                r_valid[r_cidx] <= 1'b0;
            end
            if (r_state == ST_PLAY_LD || r_state == ST_STAT) r_ov <= 1'b1;
            else if (taken)                                 r_ov <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_oid   <= i_in.order_id;
            r_cid   <= i_in.client_id;
            r_side  <= i_in.side;
            r_mkt   <= (i_in.order_type == TYPE_MARKET);
            r_tif   <= i_in.time_in_force;
            r_price <= i_in.price;
            r_rem   <= i_in.quantity;
            r_ntr   <= '0;
            r_pidx  <= '0;
        end
        // clear the scan accumulators on entry to a pass
        if (n_is_scan && (n_state != r_state)) begin
            r_bfound <= 1'b0;
            r_sum    <= '0;
            r_cfound <= 1'b0;
            r_bb     <= NO_PRICE;
            r_ba     <= NO_PRICE;
        end else if (r_dv) begin
            unique case (r_state)
                ST_FOK_SCAN: begin
                    if (elig) r_sum <= r_sum + SUMW'(r_rdata.remaining);
                end
                ST_MATCH_SCAN: begin
                    if (elig && (!r_bfound || better)) begin
                        r_bfound <= 1'b1;
                        r_bidx   <= r_didx;
                        r_bprice <= r_rdata.price;
                        r_bage   <= age;
                    end
                end
                ST_CAN_SCAN: begin
                    if (!r_cfound && r_valid[r_didx] && r_rdata.order_id == r_oid) begin
                        r_cfound <= 1'b1;
                        r_cidx   <= r_didx;
                        r_cqty   <= r_rdata.remaining;
                    end
                end
                ST_BEST_SCAN: begin
                    if (r_valid[r_didx]) begin
                        if (r_rdata.side == SIDE_BUY) begin
                            if (r_bb == NO_PRICE || {1'b0, r_rdata.price} > r_bb)
                                r_bb <= {1'b0, r_rdata.price};
                        end else if ({1'b0, r_rdata.price} < r_ba) begin
                            r_ba <= {1'b0, r_rdata.price};
                        end
                    end
                end
                default: ;
            endcase
        end
        // settle the status
        if (r_state == ST_FOK_SCAN && scan_done) begin
            r_kind     <= KIND_FOK_REJ;
            r_rest_qty <= r_rem;
        end
        if (r_state == ST_CAN_SCAN && scan_done) begin
            r_kind     <= r_cfound ? KIND_CANCELLED : KIND_CXL_UNK;
            r_rest_qty <= r_cfound ? r_cqty : 32'd0;
        end
        if (r_state == ST_REST) begin
            r_rest_qty <= r_rem;
            if ((r_rem == 32'd0) || r_mkt || (r_tif == TIF_IOC) || (r_tif == TIF_FOK))
                r_kind <= KIND_DONE;
            else if (free_found)
                r_kind <= KIND_RESTED;
            else
                r_kind <= KIND_FULL;
        end
        if (r_state == ST_FILL_WR) begin
            r_rem <= r_rem - fill;
            r_ntr <= r_ntr + 1'b1;
        end
        if (r_state == ST_PLAY_WT && taken) r_pidx <= r_pidx + 1'b1;
        // load the result register
        if (r_state == ST_PLAY_LD) begin
            r_o.kind          <= KIND_TRADE;
            r_o.trade_id      <= r_tdata.trade_id;
            r_o.fill_price    <= r_tdata.price;
            r_o.fill_quantity <= r_tdata.quantity;
            r_o.buyer_oid     <= (r_side == SIDE_BUY) ? r_oid : r_tdata.order_id;
            r_o.seller_oid    <= (r_side == SIDE_BUY) ? r_tdata.order_id : r_oid;
            r_o.buyer_cid     <= (r_side == SIDE_BUY) ? r_cid : r_tdata.client_id;
            r_o.seller_cid    <= (r_side == SIDE_BUY) ? r_tdata.client_id : r_cid;
            r_o.taker_side    <= r_side;
            r_o.best_bid      <= r_bb;
            r_o.best_ask      <= r_ba;
            r_o.last          <= 1'b0;
        end else if (r_state == ST_STAT) begin
            r_o <= '{kind: r_kind, trade_id: 32'd0, fill_price: 16'd0,
                     fill_quantity: r_rest_qty, buyer_oid: 32'd0, seller_oid: 32'd0,
                     buyer_cid: 16'd0, seller_cid: 16'd0, taker_side: 1'b0,
                     best_bid: r_bb, best_ask: r_ba, last: 1'b1};
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.kind           = r_o.kind;
    assign o_out.trade_id       = r_o.trade_id;
    assign o_out.fill_price     = r_o.fill_price;
    assign o_out.fill_quantity  = r_o.fill_quantity;
    assign o_out.buyer_oid      = r_o.buyer_oid;
    assign o_out.seller_oid     = r_o.seller_oid;
    assign o_out.buyer_cid      = r_o.buyer_cid;
    assign o_out.seller_cid     = r_o.seller_cid;
    assign o_out.taker_side     = r_o.taker_side;
    assign o_out.best_bid       = r_o.best_bid;
    assign o_out.best_ask       = r_o.best_ask;
    assign o_out.last           = r_o.last;

endmodule
`default_nettype wire
